>>> rtl/fpsm_pkg.sv
// Shared types and constants for the fixed pattern stream matcher.
// No dependencies; imported by every module of the block.
package fpsm_pkg;

    localparam int SYM_W = 8;
    localparam int POS_W = 31;

    typedef logic [SYM_W-1:0] t_sym;
    typedef logic [POS_W-1:0] t_pos;

    // Match record from the front end into the queue
    typedef struct packed {
        logic valid;
        t_pos pos;
    } t_push;

    // Queue status back to its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/fpsm_front.sv
// Front end: accepts pattern and text items, keeps pattern and text window,
// compares in parallel and issues match offsets. Depends on fpsm_pkg.
module fpsm_front #(
    parameter int MAX_PATTERN = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_is_text,
    input  logic             i_first,
    input  fpsm_pkg::t_sym   i_symbol,
    input  fpsm_pkg::t_q_stat i_q_stat,
    output logic             o_ready,
    output fpsm_pkg::t_push  o_push
);
    import fpsm_pkg::*;

    localparam int CW = $clog2(MAX_PATTERN + 1);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_PATTERN);

    // Pattern held reversed: r_prev[k] is pattern byte (count - 1 - k),
    // so it lines up lane for lane with the text window.
    t_sym          r_prev [MAX_PATTERN];
    t_sym          r_win  [MAX_PATTERN];
    logic [CW-1:0] r_pc, n_pc;
    logic [CW-1:0] r_fill, n_fill;
    logic [CW-1:0] r_skip, n_skip;
    t_pos          r_pos, n_pos;

    logic          accept;
    logic          shift_pat;
    logic          shift_txt;
    logic [CW-1:0] pc_base;
    logic [CW-1:0] fill_base;
    logic [CW-1:0] skip_base;
    t_pos          pos_base;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic          win_match;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        pc_base   = i_first ? '0 : r_pc;
        fill_base = i_first ? '0 : r_fill;
        skip_base = i_first ? '0 : r_skip;
        pos_base  = i_first ? '0 : r_pos;
    end

    // Lane k checks the window after this byte shifts in
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (CW'(k) >= r_pc) begin
                lane_ok[k] = 1'b1;
            end else if (k == 0) begin
                lane_ok[k] = (i_symbol == r_prev[0]);
            end else begin
                lane_ok[k] = (r_win[k-1] == r_prev[k]);
            end
        end
    end

    always_comb begin
        n_pc      = r_pc;
        n_fill    = r_fill;
        n_skip    = r_skip;
        n_pos     = r_pos;
        shift_pat = 1'b0;
        shift_txt = 1'b0;
        win_match = 1'b0;
        o_push    = '0;
        if (accept) begin
            if (!i_is_text) begin
                n_fill = '0;
                n_skip = '0;
                n_pos  = '0;
                n_pc   = pc_base;
                if (pc_base < MAX_C) begin
                    n_pc      = pc_base + 1'b1;
                    shift_pat = 1'b1;
                end
            end else begin
                shift_txt = 1'b1;
                n_fill = (fill_base < MAX_C) ? fill_base + 1'b1 : fill_base;
                n_pos  = (pos_base != '1) ? pos_base + 1'b1 : pos_base;
                win_match = (r_pc != '0) && (n_fill >= r_pc) && (&lane_ok);
                if (skip_base != '0) begin
                    n_skip = skip_base - 1'b1;
                end else if (win_match) begin
                    n_skip       = r_pc - 1'b1;
                    o_push.valid = 1'b1;
                    o_push.pos   = n_pos - POS_W'(r_pc) + 1'b1;
                end else begin
                    n_skip = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc   <= '0;
            r_fill <= '0;
            r_skip <= '0;
            r_pos  <= '0;
        end else begin
            r_pc   <= n_pc;
            r_fill <= n_fill;
            r_skip <= n_skip;
            r_pos  <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift_pat) begin
            r_prev[0] <= i_symbol;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_prev[k] <= r_prev[k-1];
            end
        end
        if (shift_txt) begin
            r_win[0] <= i_symbol;
            for (int k = 1; k < MAX_PATTERN; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

endmodule

>>> rtl/fpsm_queue.sv
// Two-entry queue of match offsets between front end and output stage.
// Depends on fpsm_pkg.
module fpsm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpsm_pkg::t_push   i_push,
    input  logic              i_pop,
    output fpsm_pkg::t_pos    o_data,
    output fpsm_pkg::t_q_stat o_stat
);
    import fpsm_pkg::*;

    t_pos       r_mem [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_count, n_count;
    logic       do_push;
    logic       do_pop;

    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);
    assign o_data       = r_mem[r_rptr];

    assign do_push = i_push.valid && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wptr  = do_push ? ~r_wptr : r_wptr;
        n_rptr  = do_pop ? ~r_rptr : r_rptr;
        n_count = r_count + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push.pos;
        end
    end

endmodule

>>> rtl/fpsm_back.sv
// Output stage: moves queued match offsets into the registered master port.
// Depends on fpsm_pkg.
module fpsm_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpsm_pkg::t_pos    i_data,
    input  fpsm_pkg::t_q_stat i_q_stat,
    input  logic              i_ready,
    output logic              o_pop,
    output logic              o_valid,
    output fpsm_pkg::t_pos    o_data
);
    import fpsm_pkg::*;

    logic r_valid, n_valid;
    t_pos r_data;

    assign o_pop   = !i_q_stat.empty && (!r_valid || i_ready);
    assign n_valid = o_pop || (r_valid && !i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule

>>> rtl/fixed_pattern_stream_matcher.sv
// Fixed pattern stream matcher, top level.
// Instantiates fpsm_front, fpsm_queue and fpsm_back; depends on fpsm_pkg.
//
// Usage:
//   Slave stream carries one byte per item: tdata = symbol, tuser[0] = kind
//   (0 pattern byte, 1 text byte), tuser[1] = first (restart pattern load or
//   text scan). Load up to MAX_PATTERN pattern bytes, then stream text.
//   Every pattern byte also restarts the text scan.
//   Master stream carries the 1-based start offset of each non-overlapping
//   match in tdata[30:0]; after a match the next pattern-length minus one
//   text bytes cannot complete a match.
//   Throughput: one item per cycle while s_axis_tready is high. The
//   full-window compare (MAX_PATTERN byte lanes, ANDed) is combinational
//   in the front end. A match offset passes through the queue and then
//   the output register to the master port.
//   Reset clears pattern length, text position and all handshake state;
//   pattern and window bytes are left as they are.
//   When the receiver stalls, offsets wait in the output register and a
//   two-entry queue; s_axis_tready drops only when that queue is full.
module fixed_pattern_stream_matcher #(
    parameter int MAX_PATTERN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [30:0] match_pos, [31] zero
);
    import fpsm_pkg::*;

    t_push   push;
    t_q_stat q_stat;
    t_pos    q_data;
    t_pos    out_pos;
    logic    pop;

    fpsm_front #(
        .MAX_PATTERN(MAX_PATTERN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_is_text (s_axis_tuser[0]),
        .i_first   (s_axis_tuser[1]),
        .i_symbol  (s_axis_tdata),
        .i_q_stat  (q_stat),
        .o_ready   (s_axis_tready),
        .o_push    (push)
    );

    fpsm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_stat  (q_stat)
    );

    fpsm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (q_data),
        .i_q_stat (q_stat),
        .i_ready  (m_axis_tready),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .o_data   (out_pos)
    );

    assign m_axis_tdata = {1'b0, out_pos};

endmodule

>>> tb/sv/fpsm_match_checker.sv
// Scoreboard for the fixed pattern stream matcher: item kinds and a checker
// that predicts match offsets from accepted input items and compares them.
// Depends on fpsm_pkg; the testbench top instantiates it beside the block.
`timescale 1ns / 1ps

package fpsm_tb_pkg;

    localparam int MAX_PATTERN = 64;

    // tuser[0] of an input item
    typedef enum logic {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } t_kind;

endpackage

module fpsm_match_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] symbol
    input  logic [1:0]  i_s_tuser,      // [0] req_type, [1] first
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,      // [30:0] match_pos, [31] zero
    output int          o_fail_count,
    output int          o_pending
);
    import fpsm_pkg::*;
    import fpsm_tb_pkg::*;

    localparam t_pos POS_MAX = '1;

    // Mirror of the matcher state
    t_sym       motif [MAX_PATTERN];
    logic [6:0] motif_len;
    t_sym       recent [MAX_PATTERN];   // recent[k] = text byte k places back
    logic [6:0] recent_fill;
    t_pos       text_seen;
    logic [6:0] hold_off;               // text bytes left that cannot match

    t_pos offsets_due [$];
    t_pos offset_exp;

    task automatic clear_scan();
        recent_fill = '0;
        text_seen   = '0;
        hold_off    = '0;
    endtask

    task automatic take_byte(input t_kind kind, input t_sym sym, input logic restart);
        logic hit;
        if (kind == KIND_PATTERN) begin
            if (restart) motif_len = '0;
            // bytes past the store size are dropped
            if (motif_len < MAX_PATTERN) begin
                motif[motif_len] = sym;
                motif_len++;
            end
            clear_scan();
        end else begin
            if (restart) clear_scan();
            for (int i = MAX_PATTERN - 1; i > 0; i--) recent[i] = recent[i-1];
            recent[0] = sym;
            if (recent_fill < MAX_PATTERN) recent_fill++;
            if (text_seen != POS_MAX) text_seen++;
            if (hold_off != 0) begin
                hold_off--;
            end else if (motif_len != 0 && recent_fill >= motif_len) begin
                hit = 1'b1;
                for (int j = 0; j < motif_len; j++)
                    if (recent[motif_len - 1 - j] != motif[j]) hit = 1'b0;
                if (hit) begin
                    offsets_due.insert(offsets_due.size(),
                                       t_pos'(text_seen - motif_len + 1));
                    hold_off = motif_len - 7'd1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            motif_len = '0;
            clear_scan();
            offsets_due.delete();
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                take_byte(t_kind'(i_s_tuser[0]), i_s_tdata, i_s_tuser[1]);
            if (i_m_tvalid && i_m_tready) begin
                if (offsets_due.size() == 0) begin
                    $display("%0t: match offset %0d arrived with none expected",
                             $time, i_m_tdata[30:0]);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    offset_exp = offsets_due.pop_front();
                    if (i_m_tdata[30:0] != offset_exp) begin
                        $display("%0t: match offset expected %0d, got %0d",
                                 $time, offset_exp, i_m_tdata[30:0]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= offsets_due.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Testbench top for fixed_pattern_stream_matcher: clock, reset, byte stimulus
// with random gaps and output stalls, and the final verdict.
// Depends on fpsm_pkg, fpsm_tb_pkg and fpsm_match_checker.
`timescale 1ns / 1ps

module testbench;
    import fpsm_pkg::*;
    import fpsm_tb_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] symbol
    logic [1:0]  s_axis_tuser = '0;     // [0] req_type, [1] first
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [30:0] match_pos, [31] zero

    int   mismatches;
    int   offsets_waiting;
    bit   tx_burst;                     // sender runs without gaps
    bit   rx_burst;                     // receiver runs without stalls
    int   bytes_sent;
    t_sym motif [$];
    t_sym alpha0, alpha1;

    always #4 i_clk = ~i_clk;

    fixed_pattern_stream_matcher DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fpsm_match_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (mismatches),
        .o_pending    (offsets_waiting)
    );

    // Called at a rising edge; returns at the edge that takes the item.
    task automatic send_byte(input t_kind kind, input t_sym sym, input logic restart);
        int gap;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tuser  <= {restart, kind};
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    function automatic t_sym pick_sym();
        case ($urandom_range(0, 7))
            0:       return t_sym'($urandom_range(0, 255));
            1, 2, 3: return alpha0;
            default: return alpha1;
        endcase
    endfunction

    task automatic load_motif(input int len);
        motif.delete();
        for (int i = 0; i < len; i++) begin
            motif.insert(motif.size(), pick_sym());
            // now and then append to the old pattern instead of restarting it
            send_byte(KIND_PATTERN, motif[i], i == 0 && $urandom_range(0, 9) != 0);
        end
    endtask

    task automatic send_text();
        int  units;
        int  run;
        logic lead;
        lead  = ($urandom_range(0, 7) != 0);
        units = $urandom_range(1, 8);
        for (int u = 0; u < units; u++) begin
            if ($urandom_range(0, 1) == 0) begin
                // embed a copy of the pattern, capped at the store size
                foreach (motif[i]) if (i < MAX_PATTERN) begin
                    send_byte(KIND_TEXT, motif[i], lead);
                    lead = 1'b0;
                end
            end else begin
                run = $urandom_range(1, 4);
                repeat (run) begin
                    send_byte(KIND_TEXT, pick_sym(), lead || $urandom_range(0, 40) == 0);
                    lead = 1'b0;
                end
            end
            // stray pattern byte mid text: appends and restarts the scan
            if ($urandom_range(0, 30) == 0) begin
                motif.insert(motif.size(), pick_sym());
                send_byte(KIND_PATTERN, motif[$], 1'b0);
            end
        end
    endtask

    // Receiver: random stall before each item, with stall-free stretches
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        #4_000_000;
        $display("timeout");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pattern: text counted, never matched
        send_byte(KIND_TEXT, 8'h00, 1'b1);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        // two-byte pattern, short text, then back-to-back matches
        send_byte(KIND_PATTERN, 8'hA5, 1'b1);
        send_byte(KIND_PATTERN, 8'h5A, 1'b0);
        send_byte(KIND_TEXT, 8'hA5, 1'b1);
        send_byte(KIND_TEXT, 8'h5A, 1'b0);
        send_byte(KIND_TEXT, 8'hA5, 1'b0);
        send_byte(KIND_TEXT, 8'h5A, 1'b0);
        send_byte(KIND_TEXT, 8'hA5, 1'b1);
        // overlapping candidates must not both match
        send_byte(KIND_PATTERN, 8'h00, 1'b1);
        send_byte(KIND_PATTERN, 8'h00, 1'b0);
        repeat (5) send_byte(KIND_TEXT, 8'h00, 1'b0);
        // one-byte pattern: every byte may match
        send_byte(KIND_PATTERN, 8'hFF, 1'b1);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'h7F, 1'b1);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        // appended pattern byte restarts the scan
        send_byte(KIND_PATTERN, 8'h80, 1'b0);
        send_byte(KIND_TEXT, 8'hFF, 1'b0);
        send_byte(KIND_TEXT, 8'h80, 1'b0);

        while (bytes_sent < 1880) begin
            alpha0 = t_sym'($urandom_range(0, 255));
            alpha1 = t_sym'($urandom_range(0, 255));
            case ($urandom_range(0, 15))
                0:       len = $urandom_range(65, 72);  // overflows the store
                1, 2:    len = $urandom_range(9, 64);
                default: len = $urandom_range(1, 8);
            endcase
            load_motif(len);
            repeat ($urandom_range(1, 3)) send_text();
        end
        s_axis_tvalid <= 1'b0;

        while (offsets_waiting != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatches == 0 && offsets_waiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            if (offsets_waiting != 0)
                $display("%0t: %0d match offsets never arrived", $time, offsets_waiting);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
